### rtl/core/mwdt_pkg.sv
// Package for the multi-channel watchdog table: field widths, command and
// result codes, register indexes, table entry and sequencer types.
// No dependencies.
`timescale 1ns / 1ps

package mwdt_pkg;

    localparam int MODE_W   = 2;
    localparam int CHAN_W   = 8;
    localparam int OWNER_W  = 32;
    localparam int RELOAD_W = 32;
    localparam int KIND_W   = 2;
    localparam int CHOUT_W  = 6;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 1;

    // Command codes
    localparam logic [MODE_W-1:0] MODE_REGISTER   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_UNREGISTER = 2'd1;
    localparam logic [MODE_W-1:0] MODE_KICK       = 2'd2;
    localparam logic [MODE_W-1:0] MODE_TICK       = 2'd3;

    // Result kinds
    localparam logic [KIND_W-1:0] KIND_DONE    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_PING    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_TIMEOUT = 2'd2;
    localparam logic [KIND_W-1:0] KIND_END     = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SUPPRESS = 1'd1;

    // One channel slot
    typedef struct packed {
        logic [OWNER_W-1:0]  owner;
        logic [RELOAD_W-1:0] reload_val;
        logic [RELOAD_W-1:0] countdown;
    } entry_t;

    // Write request into the channel table
    typedef struct packed {
        logic   en;
        logic   valid;
        entry_t data;
    } tbl_wr_t;

    // Sequencer states
    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_CMD  = 5'b00010,
        S_RD   = 5'b00100,
        S_EV   = 5'b01000,
        S_END  = 5'b10000
    } state_t;

endpackage

### rtl/core/mwdt_if.sv
// Valid/ready channel interfaces for the watchdog table: command in, result out.
// Depends on mwdt_pkg.
`timescale 1ns / 1ps

interface mwdt_cmd_if;
    logic                            valid;
    logic                            ready;
    logic [mwdt_pkg::MODE_W-1:0]     mode;
    logic [mwdt_pkg::CHAN_W-1:0]     channel;
    logic [mwdt_pkg::OWNER_W-1:0]    owner_id;
    logic [mwdt_pkg::RELOAD_W-1:0]   reload;

    modport source (output valid, mode, channel, owner_id, reload, input ready);
    modport sink   (input valid, mode, channel, owner_id, reload, output ready);
endinterface

interface mwdt_res_if;
    logic                            valid;
    logic                            ready;
    logic [mwdt_pkg::KIND_W-1:0]     kind;
    logic [mwdt_pkg::CHOUT_W-1:0]    channel_out;
    logic [mwdt_pkg::OWNER_W-1:0]    owner_out;
    logic                            bad_index;
    logic                            reboot;
    logic                            last;

    modport source (output valid, kind, channel_out, owner_out, bad_index, reboot, last,
                    input ready);
    modport sink   (input valid, kind, channel_out, owner_out, bad_index, reboot, last,
                    output ready);
endinterface

### rtl/core/mwdt_table.sv
// Channel table storage: one memory of slots with a registered read port and
// per-slot valid bits cleared at reset. Depends on mwdt_pkg.
`timescale 1ns / 1ps

module mwdt_table #(
    parameter int NUM_CHANNELS = 16,
    parameter int ADDR_W       = 4
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [ADDR_W-1:0]     wr_addr,
    input  mwdt_pkg::tbl_wr_t     wr,
    input  logic                  rd_en,
    input  logic [ADDR_W-1:0]     rd_addr,
    output mwdt_pkg::entry_t      rd_data
);

    mwdt_pkg::entry_t mem [NUM_CHANNELS];
    logic [NUM_CHANNELS-1:0] valid_reg;
    mwdt_pkg::entry_t rd_q_reg;
    logic rd_valid_reg;

    // Slot memory, registered read
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr_addr] <= wr.data;
        end
        if (rd_en)
        begin
            rd_q_reg <= mem[rd_addr];
        end
    end

    // Valid bits: a slot never written since reset reads as all zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr.en)
            begin
                valid_reg[wr_addr] <= wr.valid;
            end
            if (rd_en)
            begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    assign rd_data = rd_valid_reg ? rd_q_reg : '0;

endmodule

### rtl/core/multi_channel_watchdog_table_unit.sv
// Multi-channel watchdog table: top level with command sequencer, config
// registers and result register. Depends on mwdt_pkg, mwdt_if, mwdt_table.
`timescale 1ns / 1ps
//
// Usage:
//   cmd    (sink)   : register, unregister, kick or tick commands.
//   result (source) : done / ping / timeout / sweep-end results, last marks the
//                     final result of a command.
//   cfg_we/cfg_index/cfg_data: write enable and tick-suppress-reboot bits;
//   write only while the block is idle.
// Sequence: register, unregister, a disabled tick and a bad index give their
// done result from the decode state, then the block returns to idle and takes
// the next command; a kick reads the slot, then writes it back with its result.
// An enabled tick walks every slot through the shared table read port and
// decrement unit, reading and then evaluating each slot in turn, and ends
// with the sweep-end result. One command is in flight at a time; cmd.ready is
// high only in the idle state, and the result register lets the next command
// be taken while the last result still waits.
// Reset: all slots read as empty, enable = 1, suppress_reboot = 0, no result.
// Stall: a held result stops the sequencer where it has a result to give, until the result transfer.
//
module multi_channel_watchdog_table_unit #(
    parameter int NUM_CHANNELS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [mwdt_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [mwdt_pkg::CFG_DATA_W-1:0]     cfg_data,
    mwdt_cmd_if.sink                            cmd,
    mwdt_res_if.source                          result
);

    localparam int ADDR_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam logic [ADDR_W-1:0] LAST_IDX = ADDR_W'(NUM_CHANNELS - 1);
    localparam logic [mwdt_pkg::CHAN_W-1:0] NUM_CH_C = mwdt_pkg::CHAN_W'(NUM_CHANNELS);

    mwdt_pkg::state_t state_reg, state_next;
    logic [ADDR_W-1:0] idx_reg, idx_next;
    logic timed_reg, timed_next;
    logic enable_reg, suppress_reg;

    // Latched command payload
    logic [mwdt_pkg::MODE_W-1:0]   mode_reg;
    logic [mwdt_pkg::CHAN_W-1:0]   chan_reg;
    logic [mwdt_pkg::OWNER_W-1:0]  owner_reg;
    logic [mwdt_pkg::RELOAD_W-1:0] reload_reg;

    // Result register
    logic                           out_valid_reg;
    logic [mwdt_pkg::KIND_W-1:0]    kind_reg;
    logic [mwdt_pkg::CHOUT_W-1:0]   chout_reg;
    logic [mwdt_pkg::OWNER_W-1:0]   owner_out_reg;
    logic                           bad_reg, reboot_reg, last_reg;

    // Sequencer outputs
    logic                           emit;
    logic [mwdt_pkg::KIND_W-1:0]    e_kind;
    logic [mwdt_pkg::CHOUT_W-1:0]   e_chan;
    logic [mwdt_pkg::OWNER_W-1:0]   e_owner;
    logic                           e_bad, e_reboot, e_last;
    logic                           out_free, in_range, visit, cmd_xfer;
    logic [ADDR_W-1:0]              wr_addr, rd_addr;
    logic                           rd_en;
    mwdt_pkg::tbl_wr_t              wr;
    mwdt_pkg::entry_t               entry;

    mwdt_table #(
        .NUM_CHANNELS (NUM_CHANNELS),
        .ADDR_W       (ADDR_W)
    ) u_table (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_addr (wr_addr),
        .wr      (wr),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (entry)
    );

    assign cmd.ready = (state_reg == mwdt_pkg::S_IDLE);
    assign cmd_xfer  = cmd.valid && cmd.ready;
    assign out_free  = !out_valid_reg || result.ready;
    assign in_range  = (chan_reg < NUM_CH_C);
    assign visit     = (entry.owner != '0) && (entry.reload_val != '0);
    assign rd_addr   = idx_reg;

    // Sequencer: decode, table read, evaluate/write back, sweep end
    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        timed_next = timed_reg;
        emit       = 1'b0;
        e_kind     = mwdt_pkg::KIND_DONE;
        e_chan     = '0;
        e_owner    = '0;
        e_bad      = 1'b0;
        e_reboot   = 1'b0;
        e_last     = 1'b0;
        rd_en      = 1'b0;
        wr_addr    = idx_reg;
        wr         = '0;
        case (state_reg)
            mwdt_pkg::S_IDLE:
            begin
                if (cmd_xfer)
                begin
                    if (cmd.mode == mwdt_pkg::MODE_TICK && enable_reg)
                    begin
                        idx_next   = '0;
                        timed_next = 1'b0;
                        state_next = mwdt_pkg::S_RD;
                    end
                    else
                    begin
                        state_next = mwdt_pkg::S_CMD;
                    end
                end
            end
            mwdt_pkg::S_CMD:
            begin
                wr_addr = chan_reg[ADDR_W-1:0];
                if (mode_reg == mwdt_pkg::MODE_KICK && in_range)
                begin
                    idx_next   = chan_reg[ADDR_W-1:0];
                    state_next = mwdt_pkg::S_RD;
                end
                else if (out_free)
                begin
                    emit   = 1'b1;
                    e_last = 1'b1;
                    if (mode_reg != mwdt_pkg::MODE_TICK)
                    begin
                        e_bad = !in_range;
                        if (in_range)
                        begin
                            e_chan = chan_reg[mwdt_pkg::CHOUT_W-1:0];
                            wr.en  = 1'b1;
                            if (mode_reg == mwdt_pkg::MODE_REGISTER)
                            begin
                                wr.valid           = 1'b1;
                                wr.data.owner      = owner_reg;
                                wr.data.reload_val = reload_reg;
                                wr.data.countdown  = reload_reg;
                            end
                        end
                    end
                    state_next = mwdt_pkg::S_IDLE;
                end
            end
            mwdt_pkg::S_RD:
            begin
                rd_en      = 1'b1;
                state_next = mwdt_pkg::S_EV;
            end
            mwdt_pkg::S_EV:
            begin
                if (mode_reg == mwdt_pkg::MODE_KICK)
                begin
                    if (out_free)
                    begin
                        wr.en             = 1'b1;
                        wr.valid          = 1'b1;
                        wr.data           = entry;
                        wr.data.countdown = entry.reload_val;
                        emit              = 1'b1;
                        e_last            = 1'b1;
                        e_chan            = mwdt_pkg::CHOUT_W'(idx_reg);
                        state_next        = mwdt_pkg::S_IDLE;
                    end
                end
                else if (!visit || out_free)
                begin
                    if (visit)
                    begin
                        emit    = 1'b1;
                        e_chan  = mwdt_pkg::CHOUT_W'(idx_reg);
                        e_owner = entry.owner;
                        if (entry.countdown == '0)
                        begin
                            e_kind     = mwdt_pkg::KIND_TIMEOUT;
                            timed_next = 1'b1;
                        end
                        else
                        begin
                            e_kind            = mwdt_pkg::KIND_PING;
                            wr.en             = 1'b1;
                            wr.valid          = 1'b1;
                            wr.data           = entry;
                            wr.data.countdown = entry.countdown - 1'b1;
                        end
                    end
                    if (idx_reg == LAST_IDX)
                    begin
                        state_next = mwdt_pkg::S_END;
                    end
                    else
                    begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = mwdt_pkg::S_RD;
                    end
                end
            end
            mwdt_pkg::S_END:
            begin
                if (out_free)
                begin
                    emit       = 1'b1;
                    e_kind     = mwdt_pkg::KIND_END;
                    e_reboot   = timed_reg && !suppress_reg;
                    e_last     = 1'b1;
                    state_next = mwdt_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = mwdt_pkg::S_IDLE;
            end
        endcase
    end

    // Control state and config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mwdt_pkg::S_IDLE;
            idx_reg       <= '0;
            timed_reg     <= 1'b0;
            enable_reg    <= 1'b1;
            suppress_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            timed_reg <= timed_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    mwdt_pkg::CFG_ENABLE:   enable_reg   <= cfg_data[0];
                    mwdt_pkg::CFG_SUPPRESS: suppress_reg <= cfg_data[0];
                    default:                ;
                endcase
            end
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload capture
    always_ff @(posedge clk)
    begin
        if (cmd_xfer)
        begin
            mode_reg   <= cmd.mode;
            chan_reg   <= cmd.channel;
            owner_reg  <= cmd.owner_id;
            reload_reg <= cmd.reload;
        end
        if (emit)
        begin
            kind_reg      <= e_kind;
            chout_reg     <= e_chan;
            owner_out_reg <= e_owner;
            bad_reg       <= e_bad;
            reboot_reg    <= e_reboot;
            last_reg      <= e_last;
        end
    end

    assign result.valid       = out_valid_reg;
    assign result.kind        = kind_reg;
    assign result.channel_out = chout_reg;
    assign result.owner_out   = owner_out_reg;
    assign result.bad_index   = bad_reg;
    assign result.reboot      = reboot_reg;
    assign result.last        = last_reg;

endmodule

### rtl/core/mwdt_checker.sv
// Port-level checks for the watchdog table, bound to the top level.
// Depends on mwdt_pkg and multi_channel_watchdog_table_unit.
`timescale 1ns / 1ps

module mwdt_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              cmd_valid,
    input logic                              cmd_ready,
    input logic                              res_valid,
    input logic                              res_ready,
    input logic [mwdt_pkg::KIND_W-1:0]       res_kind,
    input logic [mwdt_pkg::CHOUT_W-1:0]      res_chan,
    input logic [mwdt_pkg::OWNER_W-1:0]      res_owner,
    input logic                              res_bad,
    input logic                              res_reboot,
    input logic                              res_last
);

    // One command at a time: busy right after a command transfer
    a_busy_after_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_ready |=> !cmd_ready)
        else $error("command taken while previous one in flight");

    // Reboot only on sweep end
    a_reboot_on_end: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_kind != mwdt_pkg::KIND_END |-> !res_reboot)
        else $error("reboot outside sweep end");

    // Done and sweep end close a command; ping and timeout never do
    a_last_kind: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (res_last == (res_kind == mwdt_pkg::KIND_DONE ||
                                    res_kind == mwdt_pkg::KIND_END)))
        else $error("last flag does not match result kind");

    // Bad index is a bare done result
    a_bad_done: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_bad |-> res_kind == mwdt_pkg::KIND_DONE && res_chan == '0
                                 && res_owner == '0)
        else $error("bad index result carries data");

    // Stalled result holds
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_kind) && $stable(res_owner))
        else $error("stalled result changed");

endmodule

bind multi_channel_watchdog_table_unit mwdt_checker u_mwdt_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd_valid  (cmd.valid),
    .cmd_ready  (cmd.ready),
    .res_valid  (result.valid),
    .res_ready  (result.ready),
    .res_kind   (result.kind),
    .res_chan   (result.channel_out),
    .res_owner  (result.owner_out),
    .res_bad    (result.bad_index),
    .res_reboot (result.reboot),
    .res_last   (result.last)
);

### verif/testbench.sv
`timescale 1ns / 1ps
// Testbench for multi_channel_watchdog_table_unit: directed and random command
// streams, results checked against a shadow copy of the channel table.
// Depends on mwdt_pkg, mwdt_if and the RTL top level.

module testbench;
    import mwdt_pkg::*;

    localparam int NUM_CHAN     = 16;
    localparam int SLOT_W       = $clog2(NUM_CHAN);
    localparam int CLK_HALF     = 2;
    localparam int RESET_CYCLES = 8;
    localparam int SWEEP_SLACK  = 2 * NUM_CHAN + 8;
    localparam int CFG_SLACK    = 8;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int MAX_REPORTS  = 10;
    localparam int PHASE_ITEMS  = 105;
    localparam int MAX_GAP      = 40;

    // One result as the table should produce it
    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [CHOUT_W-1:0] chan;
        logic [OWNER_W-1:0] owner;
        logic               bad;
        logic               reboot;
        logic               last;
    } wd_event_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    mwdt_cmd_if cmd_ch();
    mwdt_res_if res_ch();

    multi_channel_watchdog_table_unit #(
        .NUM_CHANNELS(NUM_CHAN)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd_ch),
        .result    (res_ch)
    );

    // Shadow channel table and registers
    logic [OWNER_W-1:0]  chan_owner  [NUM_CHAN];
    logic [RELOAD_W-1:0] chan_reload [NUM_CHAN];
    logic [RELOAD_W-1:0] chan_count  [NUM_CHAN];
    logic                sh_enable;
    logic                sh_suppress;

    wd_event_t   owed_events[$];
    int          err_count     = 0;
    int unsigned cycle_count   = 0;
    int          src_idle_pct  = 0;
    int          rcv_stall_pct = 0;
    int unsigned holdoff_req   = 0;

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #(CLK_HALF) clk = ~clk;
    end

    // Run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("multi_channel_watchdog_table_unit test failed");
            $finish;
        end
    end

    // Result side: random stalls plus a long hold-off on request
    initial
    begin
        int unsigned holdoff_left;
        holdoff_left = 0;
        res_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (holdoff_req != 0)
            begin
                holdoff_left = holdoff_req;
                holdoff_req  = 0;
            end
            if (holdoff_left != 0)
            begin
                res_ch.ready <= 1'b0;
                holdoff_left--;
            end
            else
                res_ch.ready <= ($urandom_range(99) >= rcv_stall_pct);
        end
    end

    // Compare each result transfer with the oldest owed event
    always @(posedge clk)
    begin
        wd_event_t want;
        if (rst_n === 1'b1 && res_ch.valid === 1'b1 && res_ch.ready === 1'b1)
        begin
            if (owed_events.size() == 0)
            begin
                err_count++;
                if (err_count <= MAX_REPORTS)
                    $display("unexpected result: kind=%0d ch=%0d owner=%h bad=%b rb=%b last=%b",
                             res_ch.kind, res_ch.channel_out, res_ch.owner_out,
                             res_ch.bad_index, res_ch.reboot, res_ch.last);
            end
            else
            begin
                want = owed_events.pop_front();
                if (res_ch.kind !== want.kind || res_ch.channel_out !== want.chan ||
                    res_ch.owner_out !== want.owner || res_ch.bad_index !== want.bad ||
                    res_ch.reboot !== want.reboot || res_ch.last !== want.last)
                begin
                    err_count++;
                    if (err_count <= MAX_REPORTS)
                    begin
                        $display("mismatch: exp kind=%0d ch=%0d owner=%h bad=%b rb=%b last=%b",
                                 want.kind, want.chan, want.owner, want.bad,
                                 want.reboot, want.last);
                        $display("          got kind=%0d ch=%0d owner=%h bad=%b rb=%b last=%b",
                                 res_ch.kind, res_ch.channel_out, res_ch.owner_out,
                                 res_ch.bad_index, res_ch.reboot, res_ch.last);
                    end
                end
            end
        end
    end

    function automatic void owe_event(input logic [KIND_W-1:0] kind,
                                      input logic [CHOUT_W-1:0] chan,
                                      input logic [OWNER_W-1:0] owner,
                                      input logic bad, input logic reboot,
                                      input logic last);
        wd_event_t ev;
        ev.kind   = kind;
        ev.chan   = chan;
        ev.owner  = owner;
        ev.bad    = bad;
        ev.reboot = reboot;
        ev.last   = last;
        owed_events.push_back(ev);
    endfunction

    // Update the shadow table for one command and queue the results it owes
    function automatic void apply_watchdog_cmd(input logic [MODE_W-1:0] mode,
                                               input logic [CHAN_W-1:0] chan,
                                               input logic [OWNER_W-1:0] owner,
                                               input logic [RELOAD_W-1:0] rl);
        logic              fired;
        logic [SLOT_W-1:0] slot;
        int                i;
        fired = 1'b0;
        if (mode == MODE_TICK)
        begin
            if (!sh_enable)
                owe_event(KIND_DONE, '0, '0, 1'b0, 1'b0, 1'b1);
            else
            begin
                // sweep active, monitored slots in index order
                for (i = 0; i < NUM_CHAN; i++)
                begin
                    if (chan_owner[i] != '0 && chan_reload[i] != '0)
                    begin
                        if (chan_count[i] == '0)
                        begin
                            fired = 1'b1;
                            owe_event(KIND_TIMEOUT, CHOUT_W'(i), chan_owner[i],
                                      1'b0, 1'b0, 1'b0);
                        end
                        else
                        begin
                            chan_count[i] = chan_count[i] - 1'b1;
                            owe_event(KIND_PING, CHOUT_W'(i), chan_owner[i],
                                      1'b0, 1'b0, 1'b0);
                        end
                    end
                end
                owe_event(KIND_END, '0, '0, 1'b0, fired && !sh_suppress, 1'b1);
            end
        end
        else if (chan >= NUM_CHAN)
            owe_event(KIND_DONE, '0, '0, 1'b1, 1'b0, 1'b1);
        else
        begin
            slot = chan[SLOT_W-1:0];
            case (mode)
                MODE_REGISTER:
                begin
                    chan_owner[slot]  = owner;
                    chan_reload[slot] = rl;
                    chan_count[slot]  = rl;
                end
                MODE_UNREGISTER:
                begin
                    chan_owner[slot]  = '0;
                    chan_reload[slot] = '0;
                    chan_count[slot]  = '0;
                end
                default:
                    chan_count[slot] = chan_reload[slot];
            endcase
            owe_event(KIND_DONE, chan[CHOUT_W-1:0], '0, 1'b0, 1'b0, 1'b1);
        end
    endfunction

    // Offer one command; valid stays high after the transfer so a
    // back-to-back command can follow without a bubble
    task automatic send_cmd(input logic [MODE_W-1:0] mode, input logic [CHAN_W-1:0] chan,
                            input logic [OWNER_W-1:0] owner,
                            input logic [RELOAD_W-1:0] rl);
        int gap;
        gap = 0;
        while ($urandom_range(99) < src_idle_pct && gap < MAX_GAP)
            gap++;
        if (gap != 0)
        begin
            cmd_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_ch.valid    <= 1'b1;
        cmd_ch.mode     <= mode;
        cmd_ch.channel  <= chan;
        cmd_ch.owner_id <= owner;
        cmd_ch.reload   <= rl;
        do
            @(posedge clk);
        while (cmd_ch.ready !== 1'b1);
        apply_watchdog_cmd(mode, chan, owner, rl);
    endtask

    // Drop valid and wait until every owed result has been taken
    task automatic wait_drained(input int slack);
        cmd_ch.valid <= 1'b0;
        while (owed_events.size() != 0)
            @(posedge clk);
        repeat (slack) @(posedge clk);
    endtask

    // Write both registers while idle
    task automatic set_config(input logic en, input logic sup);
        wait_drained(CFG_SLACK);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_ENABLE;
        cfg_data  <= en;
        @(posedge clk);
        sh_enable = en;
        cfg_index <= CFG_SUPPRESS;
        cfg_data  <= sup;
        @(posedge clk);
        sh_suppress = sup;
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_idling(input int src_pct, input int rcv_pct);
        src_idle_pct  = src_pct;
        rcv_stall_pct = rcv_pct;
    endtask

    function automatic logic [OWNER_W-1:0] pick_owner();
        case ($urandom_range(19))
            0, 1:    return '0;
            2:       return '1;
            default: return $urandom;
        endcase
    endfunction

    // Mostly short reloads so timeouts come often
    function automatic logic [RELOAD_W-1:0] pick_reload();
        case ($urandom_range(9))
            0:       return '0;
            1:       return $urandom;
            2:       return '1;
            default: return $urandom_range(1, 6);
        endcase
    endfunction

    function automatic logic [CHAN_W-1:0] pick_chan();
        if ($urandom_range(99) < 88)
            return CHAN_W'($urandom_range(0, NUM_CHAN - 1));
        return CHAN_W'($urandom_range(0, 255));
    endfunction

    // Weighted command mix: registers and kicks feed the ticks
    task automatic send_random_cmd();
        int w;
        w = $urandom_range(99);
        if (w < 25)
            send_cmd(MODE_REGISTER, pick_chan(), pick_owner(), pick_reload());
        else if (w < 33)
            send_cmd(MODE_UNREGISTER, pick_chan(), $urandom, $urandom);
        else if (w < 60)
            send_cmd(MODE_KICK, pick_chan(), $urandom, $urandom);
        else
            send_cmd(MODE_TICK, CHAN_W'($urandom_range(0, 255)), $urandom, $urandom);
    endtask

    // Field extremes, every command and the corner cases of the table
    task automatic test_directed();
        set_idling(0, 0);
        send_cmd(MODE_TICK, 8'd0, '0, '0);
        send_cmd(MODE_REGISTER, 8'd0, 32'hFFFF_FFFF, 32'd1);
        send_cmd(MODE_REGISTER, 8'd15, 32'd1, 32'hFFFF_FFFF);
        send_cmd(MODE_REGISTER, 8'd3, 32'd0, 32'd2);            // owner 0 stays inactive
        send_cmd(MODE_REGISTER, 8'd5, 32'hA5A5_5A5A, 32'd0);    // reload 0 not monitored
        send_cmd(MODE_REGISTER, 8'd16, 32'h1234_5678, 32'd3);   // just out of range
        send_cmd(MODE_UNREGISTER, 8'd255, '0, '0);
        send_cmd(MODE_KICK, 8'd170, '1, '1);
        send_cmd(MODE_TICK, 8'd255, '0, '0);                    // channel field ignored
        send_cmd(MODE_TICK, 8'd85, '1, '1);                     // slot 0 times out
        send_cmd(MODE_TICK, 8'd0, '0, '0);                      // and again
        send_cmd(MODE_KICK, 8'd0, '1, '1);
        send_cmd(MODE_TICK, 8'd0, '0, '0);
        send_cmd(MODE_KICK, 8'd7, '0, '0);                      // kick of an empty slot
        send_cmd(MODE_KICK, 8'd3, '0, '0);
        send_cmd(MODE_UNREGISTER, 8'd0, '0, '0);
        send_cmd(MODE_UNREGISTER, 8'd12, '0, '0);
        send_cmd(MODE_REGISTER, 8'd10, 32'h8000_0001, 32'd1);
        send_cmd(MODE_TICK, 8'd0, '0, '0);
        send_cmd(MODE_TICK, 8'd0, '0, '0);
        send_cmd(MODE_REGISTER, 8'd63, 32'h5555_AAAA, 32'd1);
        send_cmd(MODE_KICK, 8'd64, '0, '0);
        send_cmd(MODE_UNREGISTER, 8'd128, '0, '0);
        wait_drained(CFG_SLACK);
    endtask

    // Disabled ticks and reboot suppression, both registers at both values
    task automatic test_config();
        set_idling(0, 0);
        set_config(1'b0, 1'b0);
        send_cmd(MODE_TICK, 8'd0, '0, '0);
        send_cmd(MODE_TICK, 8'd1, '0, '0);
        set_config(1'b1, 1'b1);
        send_cmd(MODE_TICK, 8'd0, '0, '0);
        set_config(1'b0, 1'b1);
        send_cmd(MODE_TICK, 8'd0, '0, '0);
        set_config(1'b1, 1'b0);
        send_cmd(MODE_TICK, 8'd0, '0, '0);
        wait_drained(CFG_SLACK);
    endtask

    // Long result hold-off while commands keep coming, then a full drain
    task automatic test_backpressure();
        int i;
        set_idling(0, 0);
        holdoff_req = 250;
        for (i = 0; i < 6; i++)
            send_cmd(MODE_REGISTER, CHAN_W'(i), $urandom | 32'd1, $urandom_range(1, 3));
        for (i = 0; i < 6; i++)
            send_cmd(MODE_TICK, CHAN_W'($urandom_range(0, 255)), '0, '0);
        wait_drained(CFG_SLACK);
        for (i = 0; i < 4; i++)
            send_random_cmd();
        wait_drained(CFG_SLACK);
    endtask

    // Random traffic in each idling phase, registers changed mid-phase
    task automatic test_random();
        int ph;
        int n;
        for (ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0:       set_idling(0, 0);
                1:       set_idling(55, 0);
                2:       set_idling(0, 55);
                default: set_idling(6, 6);
            endcase
            for (n = 0; n < PHASE_ITEMS; n++)
            begin
                if (n == PHASE_ITEMS / 2)
                    set_config($urandom_range(9) != 0, 1'($urandom_range(1)));
                send_random_cmd();
            end
            set_config(1'b1, 1'b0);
        end
    endtask

    initial
    begin
        int i;
        rst_n           <= 1'b0;
        cfg_we          <= 1'b0;
        cfg_index       <= CFG_ENABLE;
        cfg_data        <= '0;
        cmd_ch.valid    <= 1'b0;
        cmd_ch.mode     <= MODE_REGISTER;
        cmd_ch.channel  <= '0;
        cmd_ch.owner_id <= '0;
        cmd_ch.reload   <= '0;
        for (i = 0; i < NUM_CHAN; i++)
        begin
            chan_owner[i]  = '0;
            chan_reload[i] = '0;
            chan_count[i]  = '0;
        end
        sh_enable   = 1'b1;
        sh_suppress = 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_config();
        test_backpressure();
        test_random();

        wait_drained(SWEEP_SLACK);
        if (err_count == 0 && owed_events.size() == 0)
            $display("multi_channel_watchdog_table_unit test passed");
        else
            $display("multi_channel_watchdog_table_unit test failed");
        $finish;
    end

endmodule
